// ----- sv/asmdu_pkg.sv -----
`default_nettype none
package asmdu_pkg;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;
    localparam logic [1:0] KIND_DIV = 2'd3;

    localparam int WORD_BITS = 32;

    typedef struct packed {
        logic [1:0]            kind;
        logic [WORD_BITS-1:0]  operand_a;
        logic [WORD_BITS-1:0]  operand_b;
    } request_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]  result_low;
        logic [WORD_BITS-1:0]  result_high;
    } result_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [WORD_BITS-1:0]  a;
        logic [WORD_BITS-1:0]  b;
    } entry_t;

    typedef struct packed {
        logic    valid;
        entry_t  entry;
    } head_t;

endpackage
`default_nettype wire

// ----- sv/asmdu_front.sv -----
`default_nettype none
module asmdu_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire asmdu_pkg::request_t request,
    output logic                     busy,
    output asmdu_pkg::head_t         head
);

    asmdu_pkg::entry_t mem_reg [2];
    logic [1:0]        count_reg, count_next;
    logic              rd_reg, rd_next;
    logic              wr_reg, wr_next;
    logic              push, pop;
    asmdu_pkg::entry_t decoded;

    always_comb
    begin
        decoded.a = request.operand_a;
        decoded.b = request.operand_b;
        unique case (request.kind)
            asmdu_pkg::KIND_ADD: decoded.op = asmdu_pkg::OP_ADD;
            asmdu_pkg::KIND_SUB: decoded.op = asmdu_pkg::OP_SUB;
            asmdu_pkg::KIND_MUL: decoded.op = asmdu_pkg::OP_MUL;
            default:             decoded.op = asmdu_pkg::OP_DIV;
        endcase
    end

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy;
    assign pop  = (count_reg != 2'd0);

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
        rd_next    = rd_reg ^ pop;
        wr_next    = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= decoded;
        end
    end

    assign head.valid = pop;
    assign head.entry = mem_reg[rd_reg];

endmodule
`default_nettype wire

// ----- sv/asmdu_back.sv -----
`default_nettype none
module asmdu_back #(
    parameter int DW = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire asmdu_pkg::head_t    head,
    output logic                     done,
    output asmdu_pkg::result_t       result
);

    // stage 0: add, sub, multiply, divide set-up; stages 1..DW: one quotient bit each
    logic              valid_reg [DW+1];
    asmdu_pkg::op_t    op_reg    [DW+1];
    logic [DW-1:0]     rem_reg   [DW+1];
    logic [DW-1:0]     quo_reg   [DW+1];
    logic [DW-1:0]     div_reg   [DW+1];

    logic [DW-1:0]          a, b;
    logic signed [2*DW-1:0] prod;
    logic [DW-1:0]          lo0, hi0;

    assign a    = head.entry.a[DW-1:0];
    assign b    = head.entry.b[DW-1:0];
    assign prod = $signed(a) * $signed(b);

    always_comb
    begin
        lo0 = quo_reg[0];
        hi0 = '0;
        case (head.entry.op)
            asmdu_pkg::OP_ADD: lo0 = a + b;
            asmdu_pkg::OP_SUB: lo0 = a - b;
            asmdu_pkg::OP_MUL:
            begin
                lo0 = prod[DW-1:0];
                hi0 = prod[2*DW-1:DW];
            end
            default: lo0 = a;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= head.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg[0]  <= head.entry.op;
        quo_reg[0] <= lo0;
        rem_reg[0] <= hi0;
        div_reg[0] <= b;
    end

    for (genvar i = 1; i <= DW; i++)
    begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {rem_reg[i-1], quo_reg[i-1][DW-1]};
        assign diff  = trial - {1'b0, div_reg[i-1]};
        assign ge    = (trial >= {1'b0, div_reg[i-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            op_reg[i]  <= op_reg[i-1];
            div_reg[i] <= div_reg[i-1];
            if (op_reg[i-1] == asmdu_pkg::OP_DIV)
            begin
                rem_reg[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                quo_reg[i] <= {quo_reg[i-1][DW-2:0], ge};
            end
            else
            begin
                rem_reg[i] <= rem_reg[i-1];
                quo_reg[i] <= quo_reg[i-1];
            end
        end
    end

    assign done               = valid_reg[DW];
    assign result.result_low  = asmdu_pkg::WORD_BITS'(quo_reg[DW]);
    assign result.result_high = asmdu_pkg::WORD_BITS'(rem_reg[DW]);

endmodule
`default_nettype wire

// ----- sv/add_sub_mul_div_unit.sv -----
// channel   | signals                 | handshake
// request   | start, busy, request    | taken when start && !busy
// result    | done, result            | one cycle strobe, no back-pressure
// A taken request passes the queue, stage 0 and the divider; one per cycle.
// The divider is DATA_WIDTH stages, one quotient bit each; all ops share it.
// Results leave in order; busy only rises if the two-entry queue fills.
// Reset clears the queue and stage valid bits; no state survives an item.
`default_nettype none
module add_sub_mul_div_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire asmdu_pkg::request_t request,
    output logic                     busy,
    output logic                     done,
    output asmdu_pkg::result_t       result
);

    asmdu_pkg::head_t head;

    asmdu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .head    (head)
    );

    asmdu_back #(.DW(DATA_WIDTH)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .done   (done),
        .result (result)
    );

endmodule
`default_nettype wire

// ----- sv/asmdu_checker.sv -----
`default_nettype none
module asmdu_checker #(
    parameter int DW = 32
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done
);

    localparam int LAT = DW + 2;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request not answered in time");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result with no request");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("queue filled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result after reset");

endmodule

bind add_sub_mul_div_unit asmdu_checker #(.DW(DATA_WIDTH)) u_asmdu_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
`default_nettype wire

// ----- verif/add_sub_mul_div_unit_tb.sv -----
`timescale 1ns / 100ps
module add_sub_mul_div_unit_tb;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    asmdu_pkg::request_t request = '0;
    logic                busy;
    logic                done;
    asmdu_pkg::result_t  result;

    asmdu_pkg::request_t pending_requests[$];
    asmdu_pkg::result_t  expected_results[$];
    int                  error_count = 0;
    int                  burst_left = 0;
    int                  gap_left = 0;
    logic                hold_off = 1'b0;
    logic                stimulus_done = 1'b0;

    add_sub_mul_div_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request),
        .busy(busy), .done(done), .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic asmdu_pkg::result_t compute_result(asmdu_pkg::request_t req);
        asmdu_pkg::result_t res;
        logic signed [63:0] prod;
        res = '0;
        case (req.kind)
            asmdu_pkg::KIND_ADD: res.result_low = req.operand_a + req.operand_b;
            asmdu_pkg::KIND_SUB: res.result_low = req.operand_a - req.operand_b;
            asmdu_pkg::KIND_MUL:
            begin
                prod = $signed({{32{req.operand_a[31]}}, req.operand_a})
                     * $signed({{32{req.operand_b[31]}}, req.operand_b});
                res.result_low  = prod[31:0];
                res.result_high = prod[63:32];
            end
            default:
            begin
                if (req.operand_b == '0)
                begin
                    res.result_low  = '1;
                    res.result_high = req.operand_a;
                end
                else
                begin
                    res.result_low  = req.operand_a / req.operand_b;
                    res.result_high = req.operand_a % req.operand_b;
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            5: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(logic [1:0] kind, logic [31:0] a, logic [31:0] b);
        asmdu_pkg::request_t req;
        req.kind      = kind;
        req.operand_a = a;
        req.operand_b = b;
        pending_requests.push_back(req);
    endtask

    // driver: bursts and gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(compute_result(request));
                pending_requests.pop_front();
            end
            if (!(start && busy))
            begin
                if (pending_requests.size() == 0 || hold_off)
                begin
                    start <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else
                begin
                    start   <= 1'b1;
                    request <= pending_requests[0];
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result low %h high %h", $time,
                         result.result_low, result.result_high);
                error_count++;
            end
            else
            begin
                if (result.result_low !== expected_results[0].result_low)
                begin
                    $display("%0t: result_low expected %h actual %h", $time,
                             expected_results[0].result_low, result.result_low);
                    error_count++;
                end
                if (result.result_high !== expected_results[0].result_high)
                begin
                    $display("%0t: result_high expected %h actual %h", $time,
                             expected_results[0].result_high, result.result_high);
                    error_count++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        for (int k = 0; k < 4; k++)
        begin
            queue_request(k[1:0], 32'h0000_0000, 32'h0000_0000);
            queue_request(k[1:0], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            queue_request(k[1:0], 32'h8000_0000, 32'h7FFF_FFFF);
            queue_request(k[1:0], 32'h7FFF_FFFF, 32'h0000_0001);
        end
        queue_request(asmdu_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000);
        queue_request(asmdu_pkg::KIND_MUL, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_request(asmdu_pkg::KIND_DIV, 32'h1234_5678, 32'h0000_0000);
        queue_request(asmdu_pkg::KIND_DIV, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_request(asmdu_pkg::KIND_DIV, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        queue_request(asmdu_pkg::KIND_DIV, 32'h0000_0005, 32'h0000_0007);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_requests.size() == 0);
        // let everything drain before the random part
        @(posedge clk);
        hold_off <= 1'b1;
        wait (expected_results.size() == 0);
        @(posedge clk);
        hold_off <= 1'b0;
        for (int i = 0; i < 700; i++)
        begin
            a = random_operand();
            b = random_operand();
            queue_request(2'($urandom_range(0, 3)), a, b);
        end
        wait (pending_requests.size() == 0);
        @(posedge clk);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("add_sub_mul_div_unit_tb: PASS");
        else
            $display("add_sub_mul_div_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        #200000;
        $display("add_sub_mul_div_unit_tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
sv/asmdu_pkg.sv
sv/asmdu_front.sv
sv/asmdu_back.sv
sv/add_sub_mul_div_unit.sv
sv/asmdu_checker.sv
verif/add_sub_mul_div_unit_tb.sv
